### hdl/lz4d_pkg.sv
// shared types and constants for the lz4 block decompressor
package lz4d_pkg;

  localparam int WindowBytes    = 65536;
  localparam int HistAw         = 16;
  localparam int MaxBlockBytes  = 1048576;
  localparam int MaxCopyPerItem = 64;
  localparam int LenW           = 21;

  localparam logic [LenW-1:0] LenSat = {LenW{1'b1}};
  localparam logic [LenW-1:0] BlkMax = LenW'(MaxBlockBytes);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LIT_OVER = 3'd1,
    ST_IN_SHORT = 3'd2,
    ST_ZERO_OFF = 3'd3,
    ST_FAR_OFF  = 3'd4,
    ST_MAT_OVER = 3'd5,
    ST_REFUSED  = 3'd6,
    ST_IGNORED  = 3'd7
  } status_t;

  localparam logic [1:0] ADDR_IN_SIZE   = 2'd0;
  localparam logic [1:0] ADDR_OUT_LIMIT = 2'd1;

  // one queued request from the front part to the back part
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } req_t;

endpackage

### hdl/lz4d_req_fifo.sv
// two-entry request queue between the front and back parts
module lz4d_req_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lz4d_pkg::req_t   push_req,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output lz4d_pkg::req_t   head
);

  lz4d_pkg::req_t slot [2];
  logic           rd_ptr;
  logic           wr_ptr;
  logic [1:0]     count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && not_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
    end
  end

endmodule

### hdl/lz4d_engine.sv
// sequence parser, history store and output stage of the decompressor
module lz4d_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lz4d_pkg::LenW-1:0] in_size,
  input  logic [lz4d_pkg::LenW-1:0] out_limit,
  input  logic                      req_valid,
  input  lz4d_pkg::req_t            req,
  output logic                      req_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                data_byte,
  output logic                      byte_valid,
  output logic                      run_last,
  output logic                      copy_pending,
  output logic [2:0]                status,
  output logic                      block_done,
  output logic [lz4d_pkg::LenW-1:0] out_total
);

  typedef enum logic [9:0] {
    PH_IDLE  = 10'b0000000001,
    PH_TOKEN = 10'b0000000010,
    PH_LITX  = 10'b0000000100,
    PH_LIT   = 10'b0000001000,
    PH_OFFLO = 10'b0000010000,
    PH_OFFHI = 10'b0000100000,
    PH_MEXT  = 10'b0001000000,
    PH_COPY  = 10'b0010000000,
    PH_DONE  = 10'b0100000000,
    PH_RUN   = 10'b1000000000
  } ph_t;

  localparam int LW = lz4d_pkg::LenW;
  localparam int LW1 = LW + 1;
  localparam int CntW = $clog2(lz4d_pkg::MaxCopyPerItem + 1);

  ph_t                   phase;
  logic [2:0]            err;
  logic [LW-1:0]         lit_left;
  logic [LW-1:0]         mat_left;
  logic [3:0]            mat_nib;
  logic [15:0]           mat_dist;
  logic [LW-1:0]         in_used;
  logic [LW-1:0]         out_used;
  logic [CntW-1:0]       run_cnt;
  logic                  run_rd;

  logic [7:0] hist [lz4d_pkg::WindowBytes];
  logic [7:0] hist_q;
  logic       hist_we;
  logic [lz4d_pkg::HistAw-1:0] hist_wa;
  logic [7:0] hist_wd;
  logic [lz4d_pkg::HistAw-1:0] hist_ra;
  logic       fwd;
  logic [7:0] last_wr;
  logic [7:0] copy_byte;

  logic [LW-1:0] in_lim;
  logic [LW-1:0] out_lim;
  assign in_lim  = (in_size  > lz4d_pkg::BlkMax) ? lz4d_pkg::BlkMax : in_size;
  assign out_lim = (out_limit > lz4d_pkg::BlkMax) ? lz4d_pkg::BlkMax : out_limit;

  // output register
  logic o_full;
  logic [7:0] o_byte;
  logic o_bv, o_last, o_cp, o_done;
  logic [2:0] o_st;
  logic [LW-1:0] o_tot;

  assign out_valid    = o_full;
  assign data_byte    = o_byte;
  assign byte_valid   = o_bv;
  assign run_last     = o_last;
  assign copy_pending = o_cp;
  assign status       = o_st;
  assign block_done   = o_done;
  assign out_total    = o_tot;

  logic o_free;
  assign o_free = !o_full || !out_stall;

  // per-request working values
  ph_t           nph;
  logic [2:0]    nerr, st;
  logic [LW-1:0] nlit, nmat, nin, nout;
  logic [3:0]    nnib;
  logic [15:0]   ndist;
  logic          emit, ebv;
  logic [7:0]    eb;
  logic          start_run;
  logic [LW-1:0] sum_lit;
  logic [LW:0]   wide;
  logic [LW:0]   chk_o, chk_i;

  function automatic logic [LW-1:0] sat_add(input logic [LW-1:0] a, input logic [7:0] b);
    logic [LW:0] s;
    s = {1'b0, a} + {{(LW-7){1'b0}}, b};
    return s[LW] ? lz4d_pkg::LenSat : s[LW-1:0];
  endfunction

  logic dec_go;
  assign dec_go  = req_valid && o_free && (phase != PH_RUN);
  assign req_pop = dec_go;

  logic [LW-1:0] src;
  assign src = out_used - {{(LW-16){1'b0}}, mat_dist};

  always_comb begin
    nph = phase; nerr = err; nlit = lit_left; nmat = mat_left; nnib = mat_nib;
    ndist = mat_dist; nin = in_used; nout = out_used;
    emit = 1'b0; ebv = 1'b0; eb = 8'd0; st = lz4d_pkg::ST_OK; start_run = 1'b0;
    wide = '0; chk_o = '0; chk_i = '0; sum_lit = '0;
    if (dec_go) begin
      emit = 1'b1;
      case (req.cmd)
        lz4d_pkg::CMD_START: begin
          nerr = '0; nlit = '0; nmat = '0; nnib = '0; ndist = '0; nin = '0; nout = '0;
          nph = (in_lim == '0) ? PH_DONE : PH_TOKEN;
        end
        lz4d_pkg::CMD_BAD: st = lz4d_pkg::ST_IGNORED;
        default: begin
          if (err != '0) begin
            st = err;
          end else if (req.cmd == lz4d_pkg::CMD_DRAIN) begin
            if (phase == PH_COPY) begin
              start_run = 1'b1; emit = 1'b0;
            end else begin
              st = lz4d_pkg::ST_IGNORED;
            end
          end else if (phase == PH_COPY) begin
            st = lz4d_pkg::ST_REFUSED;
          end else if (phase == PH_IDLE || phase == PH_DONE) begin
            st = lz4d_pkg::ST_IGNORED;
          end else if (in_used >= in_lim) begin
            nerr = lz4d_pkg::ST_IN_SHORT;
          end else begin
            nin = in_used + LW'(1);
            sum_lit = lit_left;
            case (phase)
              PH_TOKEN: begin
                nlit = LW'(req.data[7:4]);
                nnib = req.data[3:0];
                sum_lit = nlit;
                if (req.data[7:4] == 4'hF) begin
                  nph = PH_LITX;
                  if (nin >= in_lim) nerr = lz4d_pkg::ST_IN_SHORT;
                end
              end
              PH_LITX: begin
                nlit = sat_add(lit_left, req.data);
                sum_lit = nlit;
                if (req.data == 8'hFF && nin >= in_lim) nerr = lz4d_pkg::ST_IN_SHORT;
              end
              PH_LIT: begin
                ebv = 1'b1; eb = req.data;
                nout = out_used + LW'(1);
                nlit = lit_left - LW'(1);
                if (nlit == '0) nph = (nin >= in_lim) ? PH_DONE : PH_OFFLO;
              end
              PH_OFFLO: begin
                ndist = {8'd0, req.data};
                nph = PH_OFFHI;
                if (nin >= in_lim) nerr = lz4d_pkg::ST_IN_SHORT;
              end
              PH_OFFHI: begin
                ndist = {req.data, mat_dist[7:0]};
                if (ndist == '0) begin
                  nerr = lz4d_pkg::ST_ZERO_OFF;
                end else if (LW'(ndist) > out_used) begin
                  nerr = lz4d_pkg::ST_FAR_OFF;
                end else if (mat_nib == 4'hF) begin
                  nmat = LW'(19); nph = PH_MEXT;
                  if (nin >= in_lim) nerr = lz4d_pkg::ST_IN_SHORT;
                end else begin
                  nmat = LW'(mat_nib) + LW'(4);
                  wide = {1'b0, out_used} + {1'b0, nmat};
                  if (wide > {1'b0, out_lim}) nerr = lz4d_pkg::ST_MAT_OVER;
                  else begin start_run = 1'b1; emit = 1'b0; end
                end
              end
              PH_MEXT: begin
                nmat = sat_add(mat_left, req.data);
                if (req.data == 8'hFF) begin
                  if (nin >= in_lim) nerr = lz4d_pkg::ST_IN_SHORT;
                end else begin
                  wide = {1'b0, out_used} + {1'b0, nmat};
                  if (wide > {1'b0, out_lim}) nerr = lz4d_pkg::ST_MAT_OVER;
                  else begin start_run = 1'b1; emit = 1'b0; end
                end
              end
              default: ;
            endcase
            // literal length settled
            if ((phase == PH_TOKEN && req.data[7:4] != 4'hF) ||
                (phase == PH_LITX && req.data != 8'hFF)) begin
              chk_o = {1'b0, out_used} + {1'b0, sum_lit};
              chk_i = {1'b0, nin} + {1'b0, sum_lit};
              if (chk_o > {1'b0, out_lim}) nerr = lz4d_pkg::ST_LIT_OVER;
              else if (chk_i > {1'b0, in_lim}) nerr = lz4d_pkg::ST_IN_SHORT;
              else if (sum_lit == '0) nph = (nin >= in_lim) ? PH_DONE : PH_OFFLO;
              else nph = PH_LIT;
            end
          end
          if (emit && st == lz4d_pkg::ST_OK) st = nerr;
        end
      endcase
    end
  end

  // history store: one write and one registered read per cycle
  logic run_go;
  logic run_byte;
  assign run_go   = (phase == PH_RUN) && o_free && run_rd;
  assign run_byte = run_go;
  assign copy_byte = fwd ? last_wr : hist_q;

  assign hist_we = (dec_go && ebv) || run_byte;
  assign hist_wa = out_used[lz4d_pkg::HistAw-1:0];
  assign hist_wd = run_byte ? copy_byte : eb;

  always_comb begin
    hist_ra = src[lz4d_pkg::HistAw-1:0];
    if (run_byte) hist_ra = src[lz4d_pkg::HistAw-1:0] + lz4d_pkg::HistAw'(1);
    else if (start_run) hist_ra = out_used[lz4d_pkg::HistAw-1:0] - ndist;
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist[hist_wa] <= hist_wd;
    hist_q  <= hist[hist_ra];
    last_wr <= hist_wd;
  end

  logic [LW-1:0] run_mat;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; err <= '0; lit_left <= '0; mat_left <= '0; mat_nib <= '0;
      mat_dist <= '0; in_used <= '0; out_used <= '0; run_cnt <= '0; run_rd <= 1'b0;
      fwd <= 1'b0; o_full <= 1'b0;
    end else begin
      if (o_free) o_full <= 1'b0;
      run_rd <= 1'b0;
      fwd    <= 1'b0;
      if (dec_go) begin
        err <= nerr; lit_left <= nlit; mat_left <= nmat; mat_nib <= nnib;
        mat_dist <= ndist; in_used <= nin; out_used <= nout; phase <= nph;
        if (start_run) begin
          phase   <= PH_RUN;
          run_rd  <= 1'b1;
          // no byte is written while a run starts, so the first read needs no forwarding
          fwd     <= 1'b0;
        end
        if (emit) o_full <= 1'b1;
      end else if (phase == PH_RUN) begin
        if (!run_rd) begin
          run_rd <= 1'b1;
        end else if (o_free) begin
          o_full   <= 1'b1;
          out_used <= out_used + LW'(1);
          mat_left <= run_mat;
          run_cnt  <= run_cnt + CntW'(1);
          run_rd   <= 1'b1;
          fwd      <= (mat_dist == 16'd1);
          if (run_mat == '0) begin
            phase   <= (in_used >= in_lim) ? PH_DONE : PH_TOKEN;
            run_cnt <= '0;
            run_rd  <= 1'b0;
          end else if (run_cnt + CntW'(1) == CntW'(lz4d_pkg::MaxCopyPerItem)) begin
            phase   <= PH_COPY;
            run_cnt <= '0;
            run_rd  <= 1'b0;
          end
        end else begin
          run_rd <= 1'b1;
        end
      end
    end
  end

  assign run_mat = mat_left - LW'(1);

  logic run_end;
  assign run_end = (run_mat == '0) ||
                   (run_cnt + CntW'(1) == CntW'(lz4d_pkg::MaxCopyPerItem));

  // match bytes left past this request, fixed for the whole run
  logic [LW:0] run_reach;
  logic        run_more;
  assign run_reach = {1'b0, mat_left} + {{(LW1-CntW){1'b0}}, run_cnt};
  assign run_more  = run_reach > LW1'(lz4d_pkg::MaxCopyPerItem);

  always_ff @(posedge clk) begin
    if (dec_go && emit) begin
      o_byte <= eb; o_bv <= ebv; o_last <= 1'b1; o_st <= st;
      o_tot  <= nout;
      o_cp   <= (nph == PH_COPY) && (nerr == '0);
      o_done <= (nph == PH_DONE) && (nerr == '0);
    end else if (run_go) begin
      o_byte <= copy_byte; o_bv <= 1'b1; o_last <= run_end; o_st <= lz4d_pkg::ST_OK;
      o_tot  <= out_used + LW'(1);
      o_cp   <= run_more;
      o_done <= !run_more && (in_used >= in_lim);
    end
  end

  property p_no_refetch_in_run;
    @(posedge clk) disable iff (rst) (phase == PH_RUN) |-> !req_pop;
  endproperty
  assert property (p_no_refetch_in_run) else $error("request taken during copy run");

  property p_run_bytes_valid;
    @(posedge clk) disable iff (rst) run_go |=> (out_valid && byte_valid);
  endproperty
  assert property (p_run_bytes_valid) else $error("copy byte not presented");

  property p_err_holds;
    @(posedge clk) disable iff (rst)
      (err != '0 && !(req_pop && req.cmd == lz4d_pkg::CMD_START)) |=> (err == $past(err));
  endproperty
  assert property (p_err_holds) else $error("sticky error changed");

endmodule

### hdl/lz4_block_decompressor_core.sv
// top level of the lz4 block decompressor
// usage:
//   configure in_size and out_limit over the register port while idle
//   (byte addresses 0 and 4), then send a start request (cmd 0) followed
//   by one request per compressed byte (cmd 1); drain requests (cmd 2)
//   continue a match copy that still has bytes left (copy_pending)
// input channel: in_valid / in_stall with cmd and in_byte; requests enter
//   a two-entry queue, so the front accepts while the back is busy
// output channel: out_valid / out_stall with one result per output byte,
//   or a single status result when a request makes no byte; run_last marks
//   the last result of a request
// output register: a result is loaded into it as the back takes its request
//   from the queue; a match copy first does a registered history read
// throughput: while out_stall is low, one request per cycle for literals and
//   headers; a match copy yields one byte per cycle from the single history
//   read port, at most 64 per request, the rest on drain requests
// reset: clears the parser, counters, queue and output register; the
//   history store keeps stale data, which a legal block never reads
// a stalled receiver holds the output register and back-pressures the
//   queue, which raises in_stall once both entries are taken
module lz4_block_decompressor_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                cmd,
  input  logic [7:0]                in_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                data_byte,
  output logic                      byte_valid,
  output logic                      run_last,
  output logic                      copy_pending,
  output logic [2:0]                status,
  output logic                      block_done,
  output logic [lz4d_pkg::LenW-1:0] out_total
);

  // byte addresses of the two registers
  localparam logic [2:0] AddrInSize   = 3'({lz4d_pkg::ADDR_IN_SIZE, 2'b00});
  localparam logic [2:0] AddrOutLimit = 3'({lz4d_pkg::ADDR_OUT_LIMIT, 2'b00});

  logic [lz4d_pkg::LenW-1:0] in_size;
  logic [lz4d_pkg::LenW-1:0] out_limit;

  // register port, always ready
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_size   <= '0;
      out_limit <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrInSize) in_size <= pwdata[lz4d_pkg::LenW-1:0];
      else if (paddr == AddrOutLimit) out_limit <= pwdata[lz4d_pkg::LenW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == AddrInSize) begin
      prdata = {{(32-lz4d_pkg::LenW){1'b0}}, in_size};
    end else if (paddr == AddrOutLimit) begin
      prdata = {{(32-lz4d_pkg::LenW){1'b0}}, out_limit};
    end
  end

  // front: request queue
  logic           q_full;
  logic           q_ne;
  logic           q_pop;
  lz4d_pkg::req_t q_in;
  lz4d_pkg::req_t q_head;

  assign q_in.cmd  = lz4d_pkg::cmd_t'(cmd);
  assign q_in.data = in_byte;
  assign in_stall  = q_full;

  lz4d_req_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_req  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_ne),
    .head      (q_head)
  );

  // back: parser, history and output stage
  lz4d_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .in_size      (in_size),
    .out_limit    (out_limit),
    .req_valid    (q_ne),
    .req          (q_head),
    .req_pop      (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .copy_pending (copy_pending),
    .status       (status),
    .block_done   (block_done),
    .out_total    (out_total)
  );

endmodule

### test/lz4_block_decompressor_core_tb.sv
// self-checking testbench for the lz4 block decompressor core
`timescale 1ns / 1ps

module lz4_block_decompressor_core_tb;

  localparam int CycleLimit = 2000000;
  localparam int ItemTarget = 350;

  // parser phases of the decoder mirror
  typedef enum int {
    P_IDLE, P_TOKEN, P_LITEXT, P_LIT, P_OFFLO, P_OFFHI, P_MEXT, P_COPY, P_DONE
  } phase_t;

  // one output byte or status word as the core should report it
  typedef struct {
    logic [7:0]                data;
    logic                      bval;
    logic                      last;
    logic                      pend;
    lz4d_pkg::status_t         st;
    logic                      done;
    logic [lz4d_pkg::LenW-1:0] total;
  } byte_res_t;

  // one directed request; cfg rewrites the block registers before it
  typedef struct {
    bit                cfg;
    lz4d_pkg::cmd_t    c;
    logic [7:0]        b;
    bit                chk;
    lz4d_pkg::status_t st;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]                paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                cmd = lz4d_pkg::CMD_START;
  logic [7:0]                in_byte = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [7:0]                data_byte;
  logic                      byte_valid, run_last, copy_pending, block_done;
  logic [2:0]                status;
  logic [lz4d_pkg::LenW-1:0] out_total;

  lz4_block_decompressor_core dut (.*);

  always #1 clk = ~clk;

  // decoder mirror state
  logic [lz4d_pkg::LenW-1:0] reg_in_size = '0, reg_out_limit = '0;
  phase_t            ph = P_IDLE;
  lz4d_pkg::status_t err = lz4d_pkg::ST_OK;
  int unsigned       lit_left, mat_left, nib, m_dist, in_cnt, out_cnt;
  logic [7:0]        hist [0:lz4d_pkg::WindowBytes-1];
  logic [7:0]        run_b [$];
  int unsigned       run_t [$];
  bit                run_v [$];
  byte_res_t         expected_bytes [$];

  int  fails = 0;
  int  cycles = 0;
  int  n_items = 0;
  bit  quiet = 0;

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fails++;
  endtask

  function automatic int unsigned in_cap();
    return (reg_in_size > lz4d_pkg::BlkMax) ? lz4d_pkg::BlkMax : reg_in_size;
  endfunction

  function automatic int unsigned out_cap();
    return (reg_out_limit > lz4d_pkg::BlkMax) ? lz4d_pkg::BlkMax : reg_out_limit;
  endfunction

  function automatic int unsigned len_add(input int unsigned a, input int unsigned b);
    return (a + b > lz4d_pkg::LenSat) ? lz4d_pkg::LenSat : a + b;
  endfunction

  function automatic void note(input bit v, input logic [7:0] b);
    if (run_b.size() < lz4d_pkg::MaxCopyPerItem) begin
      run_b.push_back(b);
      run_v.push_back(v);
      run_t.push_back(out_cnt);
    end
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    hist[out_cnt % lz4d_pkg::WindowBytes] = b;
    out_cnt++;
    note(1'b1, b);
  endfunction

  function automatic void seq_end();
    ph = (in_cnt >= in_cap()) ? P_DONE : P_TOKEN;
  endfunction

  function automatic void copy_burst();
    int unsigned n;
    n = (mat_left < lz4d_pkg::MaxCopyPerItem) ? mat_left : lz4d_pkg::MaxCopyPerItem;
    repeat (n) begin
      put_byte(hist[(out_cnt - m_dist) % lz4d_pkg::WindowBytes]);
      mat_left--;
    end
    if (mat_left == 0) seq_end();
    else ph = P_COPY;
  endfunction

  function automatic void match_begin(input int unsigned len);
    mat_left = len;
    if (out_cnt + len > out_cap()) err = lz4d_pkg::ST_MAT_OVER;
    else copy_burst();
  endfunction

  function automatic void lit_done();
    ph = (in_cnt >= in_cap()) ? P_DONE : P_OFFLO;
  endfunction

  function automatic void lit_begin();
    if (out_cnt + lit_left > out_cap()) err = lz4d_pkg::ST_LIT_OVER;
    else if (in_cnt + lit_left > in_cap()) err = lz4d_pkg::ST_IN_SHORT;
    else if (lit_left == 0) lit_done();
    else ph = P_LIT;
  endfunction

  function automatic void need_more();
    if (in_cnt >= in_cap()) err = lz4d_pkg::ST_IN_SHORT;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    if (in_cnt >= in_cap()) begin
      err = lz4d_pkg::ST_IN_SHORT;
      return;
    end
    in_cnt++;
    case (ph)
      P_TOKEN: begin
        lit_left = b[7:4];
        nib = b[3:0];
        if (lit_left == 15) begin
          ph = P_LITEXT;
          need_more();
        end else lit_begin();
      end
      P_LITEXT: begin
        lit_left = len_add(lit_left, b);
        if (b == 8'hFF) need_more();
        else lit_begin();
      end
      P_LIT: begin
        put_byte(b);
        lit_left--;
        if (lit_left == 0) lit_done();
      end
      P_OFFLO: begin
        m_dist = b;
        ph = P_OFFHI;
        need_more();
      end
      P_OFFHI: begin
        m_dist = m_dist | (int'(b) << 8);
        if (m_dist == 0) err = lz4d_pkg::ST_ZERO_OFF;
        else if (m_dist > out_cnt) err = lz4d_pkg::ST_FAR_OFF;
        else if (nib == 15) begin
          mat_left = 19;
          ph = P_MEXT;
          need_more();
        end else match_begin(nib + 4);
      end
      P_MEXT: begin
        mat_left = len_add(mat_left, b);
        if (b == 8'hFF) need_more();
        else match_begin(mat_left);
      end
      default: ;
    endcase
  endfunction

  // works out every result that one accepted request should produce
  function automatic void decode_item(input lz4d_pkg::cmd_t c, input logic [7:0] b);
    lz4d_pkg::status_t st;
    byte_res_t         r;
    run_b.delete();
    run_v.delete();
    run_t.delete();
    st = lz4d_pkg::ST_OK;
    if (c == lz4d_pkg::CMD_START) begin
      err = lz4d_pkg::ST_OK;
      lit_left = 0; mat_left = 0; nib = 0; m_dist = 0; in_cnt = 0; out_cnt = 0;
      ph = (in_cap() == 0) ? P_DONE : P_TOKEN;
    end else if (c == lz4d_pkg::CMD_BAD) begin
      st = lz4d_pkg::ST_IGNORED;
    end else if (err != lz4d_pkg::ST_OK) begin
      st = err;
    end else if (c == lz4d_pkg::CMD_BYTE) begin
      if (ph == P_COPY) st = lz4d_pkg::ST_REFUSED;
      else if (ph == P_IDLE || ph == P_DONE) st = lz4d_pkg::ST_IGNORED;
      else begin
        parse_byte(b);
        st = err;
      end
    end else begin
      if (ph == P_COPY) begin
        copy_burst();
        st = err;
      end else st = lz4d_pkg::ST_IGNORED;
    end
    if (run_b.size() == 0) note(1'b0, 8'h00);
    foreach (run_b[k]) begin
      r.data  = run_b[k];
      r.bval  = run_v[k];
      r.last  = (k == run_b.size() - 1);
      r.pend  = (ph == P_COPY && err == lz4d_pkg::ST_OK);
      r.st    = st;
      r.done  = (ph == P_DONE && err == lz4d_pkg::ST_OK);
      r.total = run_t[k][lz4d_pkg::LenW-1:0];
      expected_bytes.push_back(r);
    end
  endfunction

  // hands one request to the core, with random idle cycles first
  task automatic push(input lz4d_pkg::cmd_t c, input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    decode_item(c, b);
    n_items++;
  endtask

  // waits for the core to go quiet, then writes one register
  task automatic cfg_write(input logic [1:0] idx, input logic [lz4d_pkg::LenW-1:0] v);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx) << 2;
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == lz4d_pkg::ADDR_IN_SIZE) reg_in_size = v;
    else reg_out_limit = v;
  endtask

  // appends a 255-extended length remainder
  function automatic void put_ext(ref logic [7:0] q [$], input int unsigned rem);
    while (rem >= 255) begin
      q.push_back(8'hFF);
      rem -= 255;
    end
    q.push_back(8'(rem));
  endfunction

  // builds one well-formed block; returns its decoded size
  function automatic int unsigned build_block(ref logic [7:0] q [$]);
    int unsigned nseq, lits, mlen, outn, off;
    outn = 0;
    q.delete();
    nseq = $urandom_range(1, 4);
    for (int s = 0; s < nseq; s++) begin
      lits = ($urandom_range(15) == 0) ? $urandom_range(15, 280) : $urandom_range(0, 18);
      if (outn == 0 && lits == 0) lits = 1;
      mlen = ($urandom_range(12) == 0) ? $urandom_range(15, 600) : $urandom_range(0, 30);
      q.push_back({4'((lits > 15) ? 15 : lits), 4'((mlen > 15) ? 15 : mlen)});
      if (lits >= 15) put_ext(q, lits - 15);
      repeat (lits) q.push_back(8'($urandom));
      outn += lits;
      if (s == nseq - 1) break;
      off = $urandom_range(1, (outn > 65535) ? 65535 : outn);
      q.push_back(off[7:0]);
      q.push_back(off[15:8]);
      if (mlen >= 15) put_ext(q, mlen - 15);
      outn += mlen + 4;
    end
    return outn;
  endfunction

  // directed requests; typed status only where it is plain from the rules
  dir_row_t dir_rows [32] = '{
    '{0, lz4d_pkg::CMD_BYTE,  8'h00, 1, lz4d_pkg::ST_IGNORED},   // byte before any start
    '{0, lz4d_pkg::CMD_BAD,   8'hFF, 1, lz4d_pkg::ST_IGNORED},
    '{0, lz4d_pkg::CMD_DRAIN, 8'h00, 1, lz4d_pkg::ST_IGNORED},   // drain with nothing pending
    '{0, lz4d_pkg::CMD_START, 8'h00, 1, lz4d_pkg::ST_OK},        // empty block, done at once
    '{0, lz4d_pkg::CMD_BYTE,  8'h5A, 1, lz4d_pkg::ST_IGNORED},   // byte after done
    '{1, lz4d_pkg::CMD_START, 8'h00, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'h2F, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'h61, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'h62, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'h00, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'h00, 1, lz4d_pkg::ST_ZERO_OFF},
    '{0, lz4d_pkg::CMD_BYTE,  8'h00, 1, lz4d_pkg::ST_ZERO_OFF},  // error stands
    '{0, lz4d_pkg::CMD_DRAIN, 8'h00, 1, lz4d_pkg::ST_ZERO_OFF},
    '{0, lz4d_pkg::CMD_START, 8'h00, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'h10, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'hFF, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'h02, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'h00, 1, lz4d_pkg::ST_FAR_OFF},   // offset reaches before start
    '{0, lz4d_pkg::CMD_START, 8'h00, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'h1F, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'h00, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'h01, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'h00, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'hFF, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'h10, 0, lz4d_pkg::ST_OK},        // 290-byte overlapping copy
    '{0, lz4d_pkg::CMD_BYTE,  8'h00, 1, lz4d_pkg::ST_REFUSED},   // byte while copying
    '{0, lz4d_pkg::CMD_DRAIN, 8'h00, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_DRAIN, 8'h00, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_DRAIN, 8'h00, 0, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_DRAIN, 8'h00, 1, lz4d_pkg::ST_OK},
    '{0, lz4d_pkg::CMD_BYTE,  8'h60, 1, lz4d_pkg::ST_IN_SHORT},  // literals run past the input
    '{0, lz4d_pkg::CMD_START, 8'h00, 0, lz4d_pkg::ST_OK}
  };

  // random receiver stalls, none during the quiet phase
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 6);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    byte_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report("result with nothing expected");
      end else begin
        e = expected_bytes.pop_front();
        if (data_byte !== e.data)
          report($sformatf("data_byte %0h want %0h", data_byte, e.data));
        if (byte_valid !== e.bval)
          report($sformatf("byte_valid %0b want %0b", byte_valid, e.bval));
        if (run_last !== e.last)
          report($sformatf("run_last %0b want %0b", run_last, e.last));
        if (copy_pending !== e.pend)
          report($sformatf("copy_pending %0b want %0b", copy_pending, e.pend));
        if (status !== e.st)
          report($sformatf("status %0d want %0d", status, e.st));
        if (block_done !== e.done)
          report($sformatf("block_done %0b want %0b", block_done, e.done));
        if (out_total !== e.total)
          report($sformatf("out_total %0d want %0d", out_total, e.total));
      end
    end
  end

  initial begin
    logic [7:0]  blk [$];
    int unsigned outn, idx, phase_no;
    logic [lz4d_pkg::LenW-1:0] isz, olim;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    cfg_write(lz4d_pkg::ADDR_IN_SIZE, '0);
    cfg_write(lz4d_pkg::ADDR_OUT_LIMIT, '0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg) begin
        cfg_write(lz4d_pkg::ADDR_IN_SIZE, lz4d_pkg::LenW'(12));
        cfg_write(lz4d_pkg::ADDR_OUT_LIMIT, lz4d_pkg::LenW'(400));
      end
      push(dir_rows[i].c, dir_rows[i].b);
      if (dir_rows[i].chk && expected_bytes[$].st != dir_rows[i].st)
        report($sformatf("row %0d status %0d want %0d", i, expected_bytes[$].st,
                         dir_rows[i].st));
    end

    // random blocks; each phase waits for the core to drain before reconfig
    phase_no = 0;
    while (n_items < ItemTarget) begin
      quiet = (phase_no >= 3 && phase_no < 7);
      outn = build_block(blk);
      case ($urandom_range(19))
        0:       isz = '0;
        1:       isz = lz4d_pkg::LenSat;
        2, 3:    isz = lz4d_pkg::LenW'(blk.size() - $urandom_range(1, 3));
        default: isz = lz4d_pkg::LenW'(blk.size());
      endcase
      case ($urandom_range(9))
        0:       olim = '0;
        1, 2:    olim = lz4d_pkg::LenW'($urandom_range(0, outn));
        default: olim = lz4d_pkg::LenSat;
      endcase
      cfg_write(lz4d_pkg::ADDR_IN_SIZE, isz);
      cfg_write(lz4d_pkg::ADDR_OUT_LIMIT, olim);
      push(lz4d_pkg::CMD_START, 8'($urandom));
      idx = 0;
      while (idx < blk.size()) begin
        if (ph == P_COPY && err == lz4d_pkg::ST_OK) begin
          if ($urandom_range(9) == 0) push(lz4d_pkg::CMD_BYTE, blk[idx]);
          else push(lz4d_pkg::CMD_DRAIN, 8'($urandom));
        end else if ($urandom_range(24) == 0) begin
          // noise: stray command or a corrupting byte
          push(lz4d_pkg::cmd_t'($urandom_range(1, 3)), 8'($urandom));
        end else begin
          push(lz4d_pkg::CMD_BYTE, blk[idx]);
          idx++;
        end
      end
      while (ph == P_COPY && err == lz4d_pkg::ST_OK) push(lz4d_pkg::CMD_DRAIN, 8'($urandom));
      if ($urandom_range(3) == 0) push(lz4d_pkg::CMD_BYTE, 8'($urandom));
      phase_no++;
    end
    quiet = 0;
    in_valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
hdl/lz4d_pkg.sv
hdl/lz4d_req_fifo.sv
hdl/lz4d_engine.sv
hdl/lz4_block_decompressor_core.sv
test/lz4_block_decompressor_core_tb.sv
